[rtl/lccs_pkg.sv]
// ----------------------------------------------------------------------------
// lccs_pkg: shared types and constants for the lighting command channel setter
// Token codes, payload structs and the control bundle of the level store.
// ----------------------------------------------------------------------------
package lccs_pkg;

  localparam int CHANNELS = 512;
  localparam int CH_AW    = $clog2(CHANNELS);

  localparam logic [2:0] TOK_RELEASE = 3'd0;
  localparam logic [2:0] TOK_AND     = 3'd1;
  localparam logic [2:0] TOK_AT      = 3'd2;
  localparam logic [2:0] TOK_FULL    = 3'd3;
  localparam logic [2:0] TOK_THRU    = 3'd4;
  localparam logic [2:0] TOK_NUMBER  = 3'd5;
  localparam logic [2:0] TOK_READ    = 3'd6;

  localparam logic [7:0] LEVEL_FULL = 8'hFF;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [15:0] value;
    logic        last_token;
  } req_t;

  typedef struct packed {
    logic [7:0] level_read;
    logic       frame_ready;
    logic       channel_dropped;
  } result_t;

  typedef struct packed {
    logic             frame_we;
    logic [CH_AW-1:0] frame_waddr;
    logic [7:0]       frame_wdata;
    logic             frame_re;
    logic [CH_AW-1:0] frame_raddr;
    logic             mask_we;
    logic [CH_AW-1:0] mask_waddr;
    logic             mask_wdata;
    logic             mask_re;
    logic [CH_AW-1:0] mask_raddr;
  } store_ctrl_t;

endpackage

[rtl/lccs_store.sv]
// ----------------------------------------------------------------------------
// lccs_store: frame level memory and channel selection memory
// One write and one registered read port on each array.
// ----------------------------------------------------------------------------
module lccs_store (
  input  logic                 clk,
  input  lccs_pkg::store_ctrl_t ctrl,
  output logic [7:0]           frame_q,
  output logic                 mask_q
);
  import lccs_pkg::*;

  logic [7:0] frame_mem [CHANNELS];
  logic       mask_mem  [CHANNELS];

  always_ff @(posedge clk) begin
    if (ctrl.frame_we) begin
      frame_mem[ctrl.frame_waddr] <= ctrl.frame_wdata;
    end
    if (ctrl.frame_re) begin
      frame_q <= frame_mem[ctrl.frame_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.mask_we) begin
      mask_mem[ctrl.mask_waddr] <= ctrl.mask_wdata;
    end
    if (ctrl.mask_re) begin
      mask_q <= mask_mem[ctrl.mask_raddr];
    end
  end

endmodule

[rtl/lighting_command_channel_setter.sv]
// ----------------------------------------------------------------------------
// lighting_command_channel_setter: console token interpreter over a level frame
// Selects channels, applies levels, releases the frame and serves level reads.
// ----------------------------------------------------------------------------
// A token transfers when start is high and busy is low; exactly one result
// follows, shown on result for the single cycle in which done is high, and
// the receiver cannot stall it. Tokens that need no read, no range and no
// sweep (AND, AT, THRU, plain number, tokens skipped after a release) answer
// on the next cycle; a read that does not end the line answers from S_READ,
// after the registered frame read. Applying a level (AT n, FULL), a release
// and any token with last_token set walk the whole selection memory through
// one shared sweep counter, one channel per cycle, after S_READ when a read
// ends the line. A THRU range marks one channel per cycle, then sweeps if the
// token ends the line. After reset the same sweep clears both memories, with
// busy high and no result.
module lighting_command_channel_setter (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  lccs_pkg::req_t    req,
  output logic              busy,
  output logic              done,
  output lccs_pkg::result_t result
);
  import lccs_pkg::*;

  localparam logic [15:0]    CH16    = 16'(CHANNELS);
  localparam logic [CH_AW:0] CH_END  = (CH_AW+1)'(CHANNELS);
  localparam logic [CH_AW-1:0] CH_TOP = CH_AW'(CHANNELS - 1);

  typedef enum logic [1:0] {S_IDLE, S_READ, S_RANGE, S_SWEEP} state_t;

  state_t state;

  // command context
  logic [CH_AW-1:0] last_ch;
  logic             last_valid;
  logic             level_mode;
  logic             range_mode;
  logic             skip_rest;

  // held result fields
  logic res_last;
  logic res_drop;

  // marks a sweep that follows a read, so the fetched level survives it
  logic prev_read;

  // sweep unit
  logic [CH_AW:0]   cnt;
  logic [CH_AW-1:0] p_addr;
  logic             p_vld;
  logic             sw_apply;
  logic             sw_zero;
  logic             sw_clr;
  logic             sw_init;
  logic [7:0]       sw_level;

  // range walker
  logic [CH_AW-1:0] rg_idx;
  logic [CH_AW-1:0] rg_top;

  store_ctrl_t ctrl;
  logic [7:0]  frame_q;
  logic        mask_q;

  // token decode
  logic             accept;
  logic             in_rng;
  logic [CH_AW-1:0] top;
  logic [CH_AW:0]   first;
  logic             d_read, d_drop, d_zero, d_apply, d_plain, d_range;
  logic             d_set_at, d_set_thru, d_clr_thru;
  logic [7:0]       d_level;
  logic             need_sweep;

  assign busy   = (state != S_IDLE);
  assign accept = start && (state == S_IDLE);
  assign in_rng = (req.value < CH16);
  assign top    = in_rng ? req.value[CH_AW-1:0] : CH_TOP;
  assign first  = {1'b0, last_ch} + (CH_AW+1)'(1);

  always_comb begin
    d_read     = 1'b0;
    d_drop     = 1'b0;
    d_zero     = 1'b0;
    d_apply    = 1'b0;
    d_plain    = 1'b0;
    d_range    = 1'b0;
    d_set_at   = 1'b0;
    d_set_thru = 1'b0;
    d_clr_thru = 1'b0;
    d_level    = LEVEL_FULL;
    if (req.req_type == TOK_READ) begin
      d_read = in_rng;
      d_drop = !in_rng;
    end else if (!skip_rest) begin
      unique case (req.req_type)
        TOK_RELEASE: d_zero = 1'b1;
        TOK_AT:      d_set_at = 1'b1;
        TOK_FULL:    d_apply = 1'b1;
        TOK_THRU:    d_set_thru = 1'b1;
        TOK_NUMBER: begin
          if (level_mode) begin
            d_apply = 1'b1;
            d_level = req.value[7:0];
          end else if (range_mode) begin
            d_clr_thru = 1'b1;
            d_drop     = !in_rng;
            d_range    = (req.value != 16'd0) && (req.value <= CH16) && last_valid
                         && (first <= {1'b0, top});
          end else begin
            d_plain = in_rng;
            d_drop  = !in_rng;
          end
        end
        default: ;  // AND and the unused code do nothing
      endcase
    end
    need_sweep = d_apply || d_zero || req.last_token;
  end

  // store port drive: sweep owns the frame write port, the mask write port is
  // shared by plain select, range marking and sweep clearing
  always_comb begin
    ctrl = '0;
    ctrl.frame_re    = accept && d_read;
    ctrl.frame_raddr = req.value[CH_AW-1:0];
    ctrl.mask_re     = (state == S_SWEEP) && (cnt != CH_END);
    ctrl.mask_raddr  = cnt[CH_AW-1:0];
    ctrl.frame_waddr = p_addr;
    ctrl.frame_wdata = sw_zero ? 8'd0 : sw_level;
    ctrl.frame_we    = (state == S_SWEEP) && p_vld && (sw_zero || (sw_apply && mask_q));
    if (state == S_SWEEP) begin
      ctrl.mask_we    = p_vld && sw_clr;
      ctrl.mask_waddr = p_addr;
      ctrl.mask_wdata = 1'b0;
    end else if (state == S_RANGE) begin
      ctrl.mask_we    = 1'b1;
      ctrl.mask_waddr = rg_idx;
      ctrl.mask_wdata = 1'b1;
    end else begin
      ctrl.mask_we    = accept && d_plain;
      ctrl.mask_waddr = req.value[CH_AW-1:0];
      ctrl.mask_wdata = 1'b1;
    end
  end

  lccs_store u_store (
    .clk     (clk),
    .ctrl    (ctrl),
    .frame_q (frame_q),
    .mask_q  (mask_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_SWEEP;
      done       <= 1'b0;
      result     <= '0;
      last_ch    <= '0;
      last_valid <= 1'b0;
      level_mode <= 1'b0;
      range_mode <= 1'b0;
      skip_rest  <= 1'b0;
      res_last   <= 1'b0;
      res_drop   <= 1'b0;
      cnt        <= '0;
      p_addr     <= '0;
      p_vld      <= 1'b0;
      sw_apply   <= 1'b0;
      sw_zero    <= 1'b1;
      sw_clr     <= 1'b1;
      sw_init    <= 1'b1;
      sw_level   <= '0;
      rg_idx     <= '0;
      rg_top     <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            // context updates; end of line wins over every mode and flag update
            if (req.last_token || d_apply) begin
              level_mode <= 1'b0;
            end else if (d_set_at) begin
              level_mode <= 1'b1;
            end
            if (req.last_token || d_clr_thru) begin
              range_mode <= 1'b0;
            end else if (d_set_thru) begin
              range_mode <= 1'b1;
            end
            if (req.last_token) begin
              skip_rest <= 1'b0;
            end else if (d_zero) begin
              skip_rest <= 1'b1;
            end
            if (req.last_token || d_apply) begin
              last_valid <= 1'b0;
            end else if (d_plain) begin
              last_valid <= 1'b1;
            end
            if (d_plain) begin
              last_ch <= req.value[CH_AW-1:0];
            end else if (d_range) begin
              last_ch <= top;
            end

            res_last <= req.last_token;
            res_drop <= d_drop;
            sw_apply <= d_apply;
            sw_zero  <= d_zero;
            sw_clr   <= req.last_token || d_apply;
            sw_init  <= 1'b0;
            sw_level <= d_level;
            cnt      <= '0;
            p_vld    <= 1'b0;
            rg_idx   <= first[CH_AW-1:0];
            rg_top   <= top;

            if (d_read) begin
              state <= S_READ;
            end else if (d_range) begin
              state <= S_RANGE;
            end else if (need_sweep) begin
              state <= S_SWEEP;
            end else begin
              done   <= 1'b1;
              result <= '{level_read: 8'd0, frame_ready: req.last_token,
                          channel_dropped: d_drop};
            end
          end
        end

        S_READ: begin
          if (res_last) begin
            state <= S_SWEEP;
          end else begin
            state <= S_IDLE;
          end
          done   <= !res_last;
          result <= '{level_read: frame_q, frame_ready: res_last,
                      channel_dropped: res_drop};
        end

        S_RANGE: begin
          rg_idx <= rg_idx + CH_AW'(1);
          if (rg_idx == rg_top) begin
            if (sw_clr) begin
              state <= S_SWEEP;
            end else begin
              state  <= S_IDLE;
              done   <= 1'b1;
              result <= '{level_read: 8'd0, frame_ready: res_last,
                          channel_dropped: res_drop};
            end
          end
        end

        S_SWEEP: begin
          // issue read of entry cnt, retire entry p_addr with last cycle's data
          if (cnt != CH_END) begin
            p_addr <= cnt[CH_AW-1:0];
            p_vld  <= 1'b1;
            cnt    <= cnt + (CH_AW+1)'(1);
          end else begin
            p_vld <= 1'b0;
            state <= S_IDLE;
            if (!sw_init) begin
              done <= 1'b1;
              // a read result keeps its level register from S_READ
              result.frame_ready     <= res_last;
              result.channel_dropped <= res_drop;
              if (!(res_last && result.level_read != 8'd0 && !sw_apply
                    && !sw_zero && prev_read)) begin
                result.level_read <= 8'd0;
              end
            end
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_read <= 1'b0;
    end else if (accept) begin
      prev_read <= d_read;
    end
  end

endmodule

[sim/tb_lighting_command_channel_setter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lighting_command_channel_setter: token-level check of the channel setter
// Drives console tokens through the start/busy handshake and predicts each
// result from a local copy of the level frame, selection and line flags.
// ----------------------------------------------------------------------------
module tb_lighting_command_channel_setter;
  import lccs_pkg::*;

  // Code 7 is not a token; the block must ignore it like AND.
  localparam logic [2:0] TOK_UNUSED = 3'd7;

  // Worst token: a THRU range over the whole frame followed by a line-end
  // sweep, plus the longest sender gap. The limit takes around a thousand
  // such tokens about three times over.
  localparam int unsigned CYCLE_LIMIT = 6_000_000;

  logic    clk;
  logic    rst;
  logic    start;
  req_t    req;
  logic    busy;
  logic    done;
  result_t result;

  lighting_command_channel_setter u_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .req    (req),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Local picture of the block: frame levels, selection and per-line flags.
  // --------------------------------------------------------------------------
  bit [7:0]  frame_lvl [CHANNELS];
  bit        sel_mask  [CHANNELS];
  bit [15:0] last_ch;
  bit        last_ok;
  bit        at_pending;
  bit        thru_pending;
  bit        release_seen;

  result_t     token_answers_q[$];   // expected results, oldest first
  result_t     answer_due;
  int unsigned tokens_sent;
  int unsigned errors;
  int unsigned sender_idle_pct;
  int unsigned cycle_count;

  // Write a level to every selected channel, then drop the selection.
  function automatic void apply_level(input bit [7:0] lvl);
    for (int i = 0; i < CHANNELS; i++) begin
      if (sel_mask[i]) frame_lvl[i] = lvl;
      sel_mask[i] = 1'b0;
    end
    last_ok    = 1'b0;
    at_pending = 1'b0;
  endfunction

  // Interpret one transferred token and return the result it must produce.
  function automatic result_t interpret_token(input req_t t);
    result_t     ans;
    int unsigned v;
    int unsigned top;
    ans = '0;
    v   = t.value;
    if (t.req_type == TOK_READ) begin
      // reads are served even after a release
      if (v < CHANNELS) ans.level_read = frame_lvl[v];
      else ans.channel_dropped = 1'b1;
    end else if (!release_seen) begin
      case (t.req_type)
        TOK_RELEASE: begin
          for (int i = 0; i < CHANNELS; i++) frame_lvl[i] = '0;
          release_seen = 1'b1;
        end
        TOK_AT:   at_pending = 1'b1;
        TOK_FULL: apply_level(LEVEL_FULL);
        TOK_THRU: thru_pending = 1'b1;
        TOK_NUMBER: begin
          if (at_pending) begin
            apply_level(t.value[7:0]);
          end else if (thru_pending) begin
            // range end: above the frame adds nothing, equal clips to the top
            if (v >= CHANNELS) ans.channel_dropped = 1'b1;
            if (v >= 1 && v <= CHANNELS && last_ok) begin
              top = (v < CHANNELS) ? v : CHANNELS - 1;
              for (int unsigned i = last_ch + 1; i <= top; i++) begin
                sel_mask[i] = 1'b1;
                last_ch     = i[15:0];
              end
            end
            thru_pending = 1'b0;
          end else if (v < CHANNELS) begin
            sel_mask[v] = 1'b1;
            last_ch     = t.value;
            last_ok     = 1'b1;
          end else begin
            ans.channel_dropped = 1'b1;
          end
        end
        default: ;   // AND and the unused code change nothing
      endcase
    end
    if (t.last_token) begin
      for (int i = 0; i < CHANNELS; i++) sel_mask[i] = 1'b0;
      last_ok      = 1'b0;
      at_pending   = 1'b0;
      thru_pending = 1'b0;
      release_seen = 1'b0;
    end
    ans.frame_ready = t.last_token;
    return ans;
  endfunction

  function automatic req_t make_token(input logic [2:0] kind, input logic [15:0] val,
                                      input logic last);
    req_t t;
    t.req_type   = kind;
    t.value      = val;
    t.last_token = last;
    return t;
  endfunction

  // Mostly in-frame channels, with weight on both frame edges and full range.
  function automatic logic [15:0] pick_channel();
    case ($urandom_range(9))
      0:       return 16'($urandom_range(0, 65535));
      1:       return 16'($urandom_range(CHANNELS - 4, CHANNELS + 4));
      2:       return 16'($urandom_range(0, 7));
      default: return 16'($urandom_range(0, CHANNELS - 1));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // One token transfer. Called at a rising edge; returns at a rising edge.
  // busy is looked at on the falling edge so the check never races the DUT.
  // --------------------------------------------------------------------------
  task automatic send_token(input req_t t);
    int unsigned gap;
    start <= 1'b1;
    req   <= t;
    do @(negedge clk); while (busy !== 1'b0);
    @(posedge clk);
    // transfer happened at this edge; expectation is queued before any result
    token_answers_q = {token_answers_q, interpret_token(t)};
    tokens_sent++;
    if ($urandom_range(99) < sender_idle_pct) begin
      // short gaps land inside sweeps, long ones let the block go idle
      gap = ($urandom_range(7) == 0) ? $urandom_range(9, 600) : $urandom_range(1, 8);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold the sender off until every outstanding result has come back.
  task automatic wait_answers_drained();
    while (token_answers_q.size() != 0) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // --------------------------------------------------------------------------
  // Result checker: done marks a single-cycle result, sampled mid-cycle.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst && done === 1'b1) begin
      if (token_answers_q.size() == 0) begin
        $error("result with no token outstanding: %p", result);
        errors++;
      end else begin
        answer_due = token_answers_q.pop_front();
        if (result.level_read !== answer_due.level_read) begin
          $error("level_read expected %0d got %0d", answer_due.level_read,
                 result.level_read);
          errors++;
        end
        if (result.frame_ready !== answer_due.frame_ready) begin
          $error("frame_ready expected %0d got %0d", answer_due.frame_ready,
                 result.frame_ready);
          errors++;
        end
        if (result.channel_dropped !== answer_due.channel_dropped) begin
          $error("channel_dropped expected %0d got %0d", answer_due.channel_dropped,
                 result.channel_dropped);
          errors++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("[lighting_command_channel_setter] ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Hand-written lines: frame edges, every token, dropped channels, THRU
  // without a start channel, THRU to zero, release skipping, unused code.
  task automatic run_directed_tokens();
    send_token(make_token(TOK_READ, 16'd0, 1'b0));
    send_token(make_token(TOK_READ, 16'hFFFF, 1'b0));            // read outside frame
    send_token(make_token(TOK_NUMBER, 16'd0, 1'b0));
    send_token(make_token(TOK_AND, 16'd0, 1'b0));
    send_token(make_token(TOK_NUMBER, 16'(CHANNELS - 1), 1'b0));
    send_token(make_token(TOK_AT, 16'd0, 1'b0));
    send_token(make_token(TOK_NUMBER, 16'hFF34, 1'b1));          // level uses low byte
    send_token(make_token(TOK_READ, 16'(CHANNELS - 1), 1'b0));
    send_token(make_token(TOK_NUMBER, 16'(CHANNELS - 2), 1'b0));
    send_token(make_token(TOK_THRU, 16'd0, 1'b0));
    send_token(make_token(TOK_NUMBER, 16'(CHANNELS), 1'b0));     // end clips to top
    send_token(make_token(TOK_FULL, 16'd0, 1'b1));
    send_token(make_token(TOK_THRU, 16'd0, 1'b0));               // no start channel
    send_token(make_token(TOK_NUMBER, 16'd5, 1'b0));
    send_token(make_token(TOK_NUMBER, 16'hFFFF, 1'b0));          // plain number dropped
    send_token(make_token(TOK_NUMBER, 16'd3, 1'b0));
    send_token(make_token(TOK_THRU, 16'd0, 1'b0));
    send_token(make_token(TOK_NUMBER, 16'd0, 1'b0));             // range end of zero
    send_token(make_token(TOK_FULL, 16'd0, 1'b1));
    send_token(make_token(TOK_READ, 16'd3, 1'b0));
    send_token(make_token(TOK_RELEASE, 16'd0, 1'b0));
    send_token(make_token(TOK_NUMBER, 16'd7, 1'b0));             // skipped
    send_token(make_token(TOK_FULL, 16'd0, 1'b0));               // skipped
    send_token(make_token(TOK_READ, 16'(CHANNELS - 1), 1'b1));   // still served
    send_token(make_token(TOK_UNUSED, 16'h5A5A, 1'b1));
    wait_answers_drained();
  endtask

  // Random command lines: mostly well formed (select, extend, set level,
  // read back), some release lines, some raw noise with random line ends.
  task automatic run_random_lines(input int unsigned idle_pct, input int unsigned count);
    req_t        line_q[$];
    int unsigned goal;
    int unsigned choice;
    int unsigned n;
    logic [15:0] ch;
    sender_idle_pct = idle_pct;
    goal = tokens_sent + count;
    while (tokens_sent < goal) begin
      line_q.delete();
      choice = $urandom_range(99);
      if (choice < 8) begin
        line_q = {line_q, make_token(TOK_RELEASE, 16'($urandom_range(0, 65535)), 1'b0)};
        n = $urandom_range(0, 3);
        repeat (n) line_q = {line_q, make_token(3'($urandom_range(0, 7)), pick_channel(),
                                                1'b0)};
        line_q[line_q.size() - 1].last_token = 1'b1;
      end else if (choice < 18) begin
        n = $urandom_range(1, 4);
        repeat (n) line_q = {line_q, make_token(3'($urandom_range(0, 7)),
                                                16'($urandom_range(0, 65535)),
                                                1'($urandom_range(0, 1)))};
      end else begin
        n = $urandom_range(1, 3);
        for (int k = 0; k < n; k++) begin
          if (k > 0 && $urandom_range(3) != 0)
            line_q = {line_q, make_token(TOK_AND, 16'($urandom_range(0, 65535)), 1'b0)};
          ch = pick_channel();
          line_q = {line_q, make_token(TOK_NUMBER, ch, 1'b0)};
          if ($urandom_range(9) < 4) begin
            line_q = {line_q, make_token(TOK_THRU, 16'($urandom_range(0, 65535)), 1'b0)};
            if ($urandom_range(4) == 0) ch = pick_channel();
            else ch = ch + 16'($urandom_range(0, 40));
            line_q = {line_q, make_token(TOK_NUMBER, ch, 1'b0)};
          end
          if ($urandom_range(7) == 0)
            line_q = {line_q, make_token(TOK_READ, pick_channel(), 1'b0)};
        end
        choice = $urandom_range(9);
        if (choice < 6) begin
          line_q = {line_q, make_token(TOK_AT, 16'($urandom_range(0, 65535)), 1'b0)};
          line_q = {line_q, make_token(TOK_NUMBER, 16'($urandom_range(0, 65535)), 1'b0)};
        end else if (choice < 9) begin
          line_q = {line_q, make_token(TOK_FULL, 16'($urandom_range(0, 65535)), 1'b0)};
        end
        n = $urandom_range(0, 3);
        repeat (n) line_q = {line_q, make_token(TOK_READ, pick_channel(), 1'b0)};
        line_q[line_q.size() - 1].last_token = 1'b1;
      end
      foreach (line_q[i]) send_token(line_q[i]);
      if ($urandom_range(39) == 0) wait_answers_drained();
    end
    wait_answers_drained();
  endtask

  // --------------------------------------------------------------------------
  // Sequence: reset once, directed lines, then random lines at three idle
  // rates, then a quiet tail to catch stray results.
  // --------------------------------------------------------------------------
  initial begin
    rst             <= 1'b1;
    start           <= 1'b0;
    req             <= '0;
    errors          = 0;
    tokens_sent     = 0;
    cycle_count     = 0;
    sender_idle_pct = 0;
    last_ch         = '0;
    last_ok         = 1'b0;
    at_pending      = 1'b0;
    thru_pending    = 1'b0;
    release_seen    = 1'b0;
    foreach (frame_lvl[i]) frame_lvl[i] = '0;
    foreach (sel_mask[i]) sel_mask[i] = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed_tokens();
    run_random_lines(30, 320);
    run_random_lines(58, 320);
    run_random_lines(0, 310);

    wait_answers_drained();
    repeat (2 * CHANNELS + 16) @(posedge clk);
    if (errors == 0) begin
      $display("[lighting_command_channel_setter] OK");
    end else begin
      $display("[lighting_command_channel_setter] ERROR");
    end
    $finish;
  end

endmodule
